// File: rtl/tts_pkg.sv
// Shared constants, types and helpers for the triangle transform/shade/cull block.
// No dependencies.
`default_nettype none

package tts_pkg;

    localparam int SCREEN_CENTER   = 360;
    localparam int CAMERA_DISTANCE = 800;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 60;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;

    localparam logic [53:0] ROW0_RST  = 54'd65536;
    localparam logic [53:0] ROW1_RST  = 54'd65536 << 18;
    localparam logic [53:0] ROW2_RST  = 54'd65536 << 36;
    localparam logic [31:0] SCALE_RST = 32'd896000;

    // quotient bits kept; anything larger saturates the screen coordinate
    localparam int Q_BITS    = 17;
    localparam int DIV_LAT   = Q_BITS + 2;
    localparam int LANE_PRE  = 5;
    localparam int LANE_LAT  = LANE_PRE + DIV_LAT;
    localparam int SHADE_LAT = 6;

    localparam logic signed [25:0] DEPTH_BIAS = 26'(CAMERA_DISTANCE * 256);

    localparam logic [15:0] K_NZ  = 16'd52429;
    localparam logic [15:0] K_NX  = 16'd13107;
    localparam logic [22:0] K_AMB = 23'd9830;

    // floor(a/3) = (a * RECIP3) >> RECIP3_SHIFT for a < 2^27
    localparam logic [26:0] RECIP3       = 27'd89478486;
    localparam int          RECIP3_SHIFT = 28;

    typedef logic signed [15:0] coord_t;

    typedef struct packed {
        coord_t             x;
        coord_t             y;
        logic signed [24:0] z;
        logic               front;
    } lane_res_t;

    function automatic logic signed [17:0] coef(input logic [53:0] row, input int j);
        return $signed(row[18*j +: 18]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/tts_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed result
// offset by the screen center and saturated to 16 bits. Uses tts_pkg.
`default_nettype none

module tts_div
    import tts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [47:0] dividend,
    input  wire logic [24:0] divisor,
    input  wire logic        neg,
    output coord_t           coord
);

    logic [41:0]       rem_reg [Q_BITS+1];
    logic [24:0]       den_reg [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg   [Q_BITS+1];
    logic              neg_reg [Q_BITS+1];
    logic              ovf_reg [Q_BITS+1];

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= dividend >= {6'd0, divisor, 17'd0};
        rem_reg[0] <= dividend[41:0];
        den_reg[0] <= divisor;
        neg_reg[0] <= neg;
        q_reg[0]   <= '0;
    end

    for (genvar k = 1; k <= Q_BITS; k++)
    begin : g_step
        localparam int B = Q_BITS - k;
        logic [42:0] trial;

        assign trial = {1'b0, rem_reg[k-1]} - {1'b0, 42'(den_reg[k-1]) << B};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= trial[42] ? rem_reg[k-1] : trial[41:0];
            q_reg[k]   <= {q_reg[k-1][Q_BITS-2:0], ~trial[42]};
            den_reg[k] <= den_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    logic signed [18:0] qs;
    logic signed [18:0] val;
    logic signed [18:0] sum;
    coord_t             coord_next;

    always_comb
    begin
        qs  = $signed({2'b00, q_reg[Q_BITS]});
        val = neg_reg[Q_BITS] ? -qs : qs;
        sum = val + 19'(SCREEN_CENTER);
        if (ovf_reg[Q_BITS])
            coord_next = neg_reg[Q_BITS] ? 16'sh8000 : 16'sh7FFF;
        else if (sum > 19'sd32767)
            coord_next = 16'sh7FFF;
        else if (sum < -19'sd32768)
            coord_next = 16'sh8000;
        else
            coord_next = sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        coord <= coord_next;
    end

endmodule

`default_nettype wire

// File: rtl/tts_lane.sv
// One vertex lane: offset, rotate, scale and perspective divide.
// Uses tts_pkg and tts_div.
`default_nettype none

module tts_lane
    import tts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [59:0] vertex,
    input  wire logic [53:0] row0,
    input  wire logic [53:0] row1,
    input  wire logic [53:0] row2,
    input  wire logic [59:0] offset,
    input  wire logic [31:0] scale,
    output lane_res_t        res
);

    logic [53:0]        rows [3];
    logic signed [17:0] m    [3][3];

    always_comb
    begin
        rows[0] = row0;
        rows[1] = row1;
        rows[2] = row2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = coef(rows[i], j);
    end

    logic signed [20:0] v_reg [3];
    logic signed [38:0] p_reg [3][3];
    logic signed [24:0] r_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            v_reg[i] <= $signed({vertex[20*i+19], vertex[20*i +: 20]})
                      - $signed({offset[20*i+19], offset[20*i +: 20]});
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p_reg[i][j] <= v_reg[j] * m[i][j];
    end

    logic signed [40:0] rsum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rsum[i] = 41'(p_reg[i][0]) + 41'(p_reg[i][1]) + 41'(p_reg[i][2]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            r_reg[i] <= rsum[i][40:16];
    end

    logic signed [25:0] d;
    logic signed [56:0] numx_reg, numy_reg;
    logic [24:0]        d_reg;
    logic               front4_reg;
    logic signed [24:0] z4_reg;

    assign d = 26'(r_reg[2]) + DEPTH_BIAS;

    always_ff @(posedge clk)
    begin
        numx_reg   <= r_reg[0] * $signed({1'b0, scale});
        numy_reg   <= r_reg[1] * $signed({1'b0, scale});
        d_reg      <= d[24:0];
        front4_reg <= !d[25] && (d != '0);
        z4_reg     <= r_reg[2];
    end

    logic [56:0] absx, absy;
    logic [47:0] ax_reg, ay_reg;
    logic        negx_reg, negy_reg;
    logic [24:0] den_reg;
    logic        front5_reg;
    logic signed [24:0] z5_reg;

    always_comb
    begin
        absx = numx_reg[56] ? 57'(-numx_reg) : 57'(numx_reg);
        absy = numy_reg[56] ? 57'(-numy_reg) : 57'(numy_reg);
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= absx[55:8];
        ay_reg     <= absy[55:8];
        negx_reg   <= numx_reg[56];
        negy_reg   <= numy_reg[56];
        den_reg    <= d_reg;
        front5_reg <= front4_reg;
        z5_reg     <= z4_reg;
    end

    coord_t px, py;

    tts_div u_div_x (
        .clk      (clk),
        .dividend (ax_reg),
        .divisor  (den_reg),
        .neg      (negx_reg),
        .coord    (px)
    );

    tts_div u_div_y (
        .clk      (clk),
        .dividend (ay_reg),
        .divisor  (den_reg),
        .neg      (negy_reg),
        .coord    (py)
    );

    logic signed [24:0] zd_reg  [DIV_LAT];
    logic               fd_reg  [DIV_LAT];

    always_ff @(posedge clk)
    begin
        zd_reg[0] <= z5_reg;
        fd_reg[0] <= front5_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            zd_reg[i] <= zd_reg[i-1];
            fd_reg[i] <= fd_reg[i-1];
        end
    end

    assign res = '{x: px, y: py, z: zd_reg[DIV_LAT-1], front: fd_reg[DIV_LAT-1]};

endmodule

`default_nettype wire

// File: rtl/tts_shade.sv
// Flat shading: rotates the normal, forms the intensity and scales the color.
// Uses tts_pkg.
`default_nettype none

module tts_shade
    import tts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [47:0] normal,
    input  wire logic [15:0] color,
    input  wire logic [53:0] row0,
    input  wire logic [53:0] row2,
    output logic [15:0]      shaded
);

    logic [53:0]        rows [2];
    logic signed [33:0] pn_reg [2][3];
    logic signed [35:0] rn_reg [2];
    logic [21:0]        ax_reg, az_reg;
    logic [37:0]        pz_reg, px_reg;
    logic [22:0]        inten_reg;
    logic [15:0]        col_reg [SHADE_LAT-1];

    assign rows[0] = row0;
    assign rows[1] = row2;

    logic [35:0] mag0, mag2;
    logic [38:0] isum;
    logic [22:0] inten;

    always_comb
    begin
        mag0  = rn_reg[0][35] ? 36'(-rn_reg[0]) : 36'(rn_reg[0]);
        mag2  = rn_reg[1][35] ? 36'(-rn_reg[1]) : 36'(rn_reg[1]);
        isum  = 39'(pz_reg) + 39'(px_reg);
        inten = isum[38:16];
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 2; r++)
            for (int j = 0; j < 3; j++)
                pn_reg[r][j] <= $signed(normal[16*j +: 16]) * coef(rows[r], j);
        for (int r = 0; r < 2; r++)
            rn_reg[r] <= 36'(pn_reg[r][0]) + 36'(pn_reg[r][1]) + 36'(pn_reg[r][2]);
        ax_reg    <= mag0[35:14];
        az_reg    <= mag2[35:14];
        pz_reg    <= az_reg * K_NZ;
        px_reg    <= ax_reg * K_NX;
        inten_reg <= (inten < K_AMB) ? K_AMB : inten;
        col_reg[0] <= color;
        for (int i = 1; i < SHADE_LAT-1; i++)
            col_reg[i] <= col_reg[i-1];
    end

    logic [15:0] c;
    logic [30:0] pr, pg, pb;
    logic [7:0]  r8, g8, b8;

    always_comb
    begin
        c  = col_reg[SHADE_LAT-2];
        pr = {c[15:11], 3'b000} * inten_reg;
        pg = {c[10:5], 2'b00} * inten_reg;
        pb = {c[4:0], 3'b000} * inten_reg;
        r8 = (pr[30:16] > 15'd255) ? 8'hFF : pr[23:16];
        g8 = (pg[30:16] > 15'd255) ? 8'hFF : pg[23:16];
        b8 = (pb[30:16] > 15'd255) ? 8'hFF : pb[23:16];
    end

    always_ff @(posedge clk)
    begin
        shaded <= {r8[7:3], g8[7:2], b8[7:3]};
    end

endmodule

`default_nettype wire

// File: rtl/tts_merge.sv
// Merge stage: back-face and depth cull, y extent and mean depth.
// Uses tts_pkg.
`default_nettype none

module tts_merge
    import tts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire lane_res_t   l0,
    input  wire lane_res_t   l1,
    input  wire lane_res_t   l2,
    input  wire logic [15:0] color,
    output logic             done,
    output coord_t           x0,
    output coord_t           y0,
    output coord_t           x1,
    output coord_t           y1,
    output coord_t           x2,
    output coord_t           y2,
    output logic signed [23:0] depth,
    output logic [15:0]      shaded,
    output coord_t           ymin,
    output coord_t           ymax
);

    typedef struct packed {
        coord_t      x0, y0, x1, y1, x2, y2;
        coord_t      lo, hi;
        logic [15:0] color;
    } carry_t;

    logic v1_reg, v2_reg, v3_reg;
    logic k1_reg, k2_reg, k3_reg;
    carry_t c1_reg, c2_reg, c3_reg;
    logic signed [33:0] pa_reg, pb_reg;
    logic signed [26:0] zsum_reg;
    logic [25:0] zabs_reg;
    logic        zneg2_reg, zneg3_reg;
    logic [24:0] zq_reg;

    coord_t lo, hi;
    logic signed [16:0] dx1, dy2, dy1, dx2;
    logic signed [34:0] area;
    logic [52:0]        zprod;

    always_comb
    begin
        lo  = l0.y;
        hi  = l0.y;
        if (l1.y < lo) lo = l1.y;
        if (l1.y > hi) hi = l1.y;
        if (l2.y < lo) lo = l2.y;
        if (l2.y > hi) hi = l2.y;
        dx1   = 17'(l1.x) - 17'(l0.x);
        dy2   = 17'(l2.y) - 17'(l0.y);
        dy1   = 17'(l1.y) - 17'(l0.y);
        dx2   = 17'(l2.x) - 17'(l0.x);
        area  = 35'(pa_reg) - 35'(pb_reg);
        zprod = zabs_reg * RECIP3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            done   <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            done   <= v3_reg && k3_reg;
        end
    end

    logic signed [25:0] mean;

    always_comb
    begin
        mean = zneg3_reg ? -$signed({1'b0, zq_reg}) : $signed({1'b0, zq_reg});
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= dx1 * dy2;
        pb_reg   <= dy1 * dx2;
        zsum_reg <= 27'(l0.z) + 27'(l1.z) + 27'(l2.z);
        k1_reg   <= l0.front && l1.front && l2.front;
        c1_reg   <= '{x0: l0.x, y0: l0.y, x1: l1.x, y1: l1.y, x2: l2.x, y2: l2.y,
                      lo: lo, hi: hi, color: color};

        k2_reg    <= k1_reg && !(area > 35'sd0);
        zabs_reg  <= zsum_reg[26] ? 26'(-zsum_reg) : 26'(zsum_reg);
        zneg2_reg <= zsum_reg[26];
        c2_reg    <= c1_reg;

        k3_reg    <= k2_reg;
        zq_reg    <= zprod[52:RECIP3_SHIFT];
        zneg3_reg <= zneg2_reg;
        c3_reg    <= c2_reg;

        x0     <= c3_reg.x0;
        y0     <= c3_reg.y0;
        x1     <= c3_reg.x1;
        y1     <= c3_reg.y1;
        x2     <= c3_reg.x2;
        y2     <= c3_reg.y2;
        ymin   <= c3_reg.lo;
        ymax   <= c3_reg.hi;
        shaded <= c3_reg.color;
        if (mean > 26'sd8388607)
            depth <= 24'sh7FFFFF;
        else if (mean < -26'sd8388608)
            depth <= 24'sh800000;
        else
            depth <= mean[23:0];
    end

endmodule

`default_nettype wire

// File: rtl/triangle_transform_shade_cull.sv
// Top level of the triangle transform, shade and cull block.
// Uses tts_pkg, tts_lane, tts_shade and tts_merge.
//
// An item (one triangle) is taken at each clock edge where start is high;
// busy is always low, so one triangle can enter every cycle.
// Three vertex lanes run side by side (offset, rotate, multiply by the
// projection scale, 17-bit pipelined divide); a shading unit runs beside
// them, and a merge stage culls back-facing triangles and triangles with a
// non-positive depth, finds the y extent and the mean depth.
// A kept triangle shows on the result ports with done high once it has passed
// through the pipeline (5 lane stages, 19 divider stages, 4 merge stages).
// Throughput: one triangle per cycle. Culled triangles give no done pulse.
// Each result stays one cycle; the receiver cannot stall.
// Configuration: cfg_we with cfg_index and cfg_data writes one register
// (0..2 matrix rows, 3 centre offset, 4 projection scale); other indexes
// are ignored. Write only while no triangle is in flight.
// Reset (rst_n low) empties the pipeline and loads the identity matrix,
// a zero offset and a scale of 3500.0.
`default_nettype none

module triangle_transform_shade_cull
    import tts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [47:0]          face_normal,
    input  wire logic [59:0]          vertex0,
    input  wire logic [59:0]          vertex1,
    input  wire logic [59:0]          vertex2,
    input  wire logic [15:0]          base_color,
    output logic                      done,
    output coord_t                    screen_x0,
    output coord_t                    screen_y0,
    output coord_t                    screen_x1,
    output coord_t                    screen_y1,
    output coord_t                    screen_x2,
    output coord_t                    screen_y2,
    output logic signed [23:0]        mean_depth,
    output logic [15:0]               shaded_color,
    output coord_t                    top_y,
    output coord_t                    bottom_y
);

    logic [53:0] row0_reg, row1_reg, row2_reg;
    logic [59:0] offset_reg;
    logic [31:0] scale_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg   <= ROW0_RST;
            row1_reg   <= ROW1_RST;
            row2_reg   <= ROW2_RST;
            offset_reg <= '0;
            scale_reg  <= SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0:   row0_reg   <= cfg_data[53:0];
                REG_ROW1:   row1_reg   <= cfg_data[53:0];
                REG_ROW2:   row2_reg   <= cfg_data[53:0];
                REG_OFFSET: offset_reg <= cfg_data;
                REG_SCALE:  scale_reg  <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    logic vld_reg [LANE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < LANE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    lane_res_t res0, res1, res2;

    tts_lane u_lane0 (
        .clk (clk), .vertex (vertex0), .row0 (row0_reg), .row1 (row1_reg),
        .row2 (row2_reg), .offset (offset_reg), .scale (scale_reg), .res (res0)
    );

    tts_lane u_lane1 (
        .clk (clk), .vertex (vertex1), .row0 (row0_reg), .row1 (row1_reg),
        .row2 (row2_reg), .offset (offset_reg), .scale (scale_reg), .res (res1)
    );

    tts_lane u_lane2 (
        .clk (clk), .vertex (vertex2), .row0 (row0_reg), .row1 (row1_reg),
        .row2 (row2_reg), .offset (offset_reg), .scale (scale_reg), .res (res2)
    );

    logic [15:0] shade;

    tts_shade u_shade (
        .clk    (clk),
        .normal (face_normal),
        .color  (base_color),
        .row0   (row0_reg),
        .row2   (row2_reg),
        .shaded (shade)
    );

    localparam int CDLY = LANE_LAT - SHADE_LAT;

    logic [15:0] cd_reg [CDLY];

    always_ff @(posedge clk)
    begin
        cd_reg[0] <= shade;
        for (int i = 1; i < CDLY; i++)
            cd_reg[i] <= cd_reg[i-1];
    end

    tts_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_reg[LANE_LAT-1]),
        .l0       (res0),
        .l1       (res1),
        .l2       (res2),
        .color    (cd_reg[CDLY-1]),
        .done     (done),
        .x0       (screen_x0),
        .y0       (screen_y0),
        .x1       (screen_x1),
        .y1       (screen_y1),
        .x2       (screen_x2),
        .y2       (screen_y2),
        .depth    (mean_depth),
        .shaded   (shaded_color),
        .ymin     (top_y),
        .ymax     (bottom_y)
    );

endmodule

`default_nettype wire
